FILE: design/rpwq_pkg.sv
// ----------------------------------------------------------------------------
// rpwq_pkg: shared types and codes for the slot pool with wait queue
// Outcome codes, fixed field widths and the FIFO control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rpwq_pkg;

  // Fixed field widths
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned COUNT_W   = 7;

  // Default sizes
  localparam int unsigned DEF_POOL_SLOTS     = 64;
  localparam int unsigned DEF_WAIT_DEPTH     = 64;
  localparam int unsigned DEF_REQUESTER_BITS = 8;

  // Request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_GRANT_NOW = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_QUEUED    = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_RETURNED  = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_WAIT_FULL = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_OVERFULL  = 3'd4;

  // Push / pop strobes for one FIFO
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage : rpwq_pkg

`default_nettype wire

FILE: design/resource_pool_with_wait_queue.sv
// ----------------------------------------------------------------------------
// resource_pool_with_wait_queue: slot pool with a FIFO of waiting requesters
// Allocate requests take a free slot or join the wait queue (refused when it is full); free requests
// hand the slot to the oldest waiter or return it to the free list (refused when it is full).
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   --------  ---------  ----------------------  --------------------------------
//   in        input      in_valid_i/in_ready_o   action, requester_id, slot_index
//   out       output     out_valid_o/out_ready_i granted, grant_requester,
//                                                grant_slot, outcome,
//                                                free_slots, waiting_requests
//
// Each request is captured while both FIFO memories read their head entries,
// then decided, which updates pointers and counters.
// The memory read is registered, which is why capture and decide are separate steps.
// After reset the free list holds slot indices 0..POOL_SLOTS-1 in order with
// no clearing pass; the wait queue is empty.
// The result sits in an output register; a new request is accepted while it
// waits, and the decide step holds until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_pool_with_wait_queue #(
  parameter int unsigned POOL_SLOTS     = rpwq_pkg::DEF_POOL_SLOTS,
  parameter int unsigned WAIT_DEPTH     = rpwq_pkg::DEF_WAIT_DEPTH,
  parameter int unsigned REQUESTER_BITS = rpwq_pkg::DEF_REQUESTER_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                action_i,
  input  wire logic [REQUESTER_BITS-1:0]           requester_id_i,
  input  wire logic [rpwq_pkg::SLOT_W-1:0]         slot_index_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     granted_o,
  output logic      [REQUESTER_BITS-1:0]           grant_requester_o,
  output logic      [rpwq_pkg::SLOT_W-1:0]         grant_slot_o,
  output logic      [rpwq_pkg::OUTCOME_W-1:0]      outcome_o,
  output logic      [rpwq_pkg::COUNT_W-1:0]        free_slots_o,
  output logic      [rpwq_pkg::COUNT_W-1:0]        waiting_requests_o
);
  import rpwq_pkg::*;

  localparam int unsigned FreeLvlW = $clog2(POOL_SLOTS + 1);
  localparam int unsigned WaitLvlW = $clog2(WAIT_DEPTH + 1);
  localparam logic [FreeLvlW-1:0] FreeFull = FreeLvlW'(POOL_SLOTS);
  localparam logic [WaitLvlW-1:0] WaitFull = WaitLvlW'(WAIT_DEPTH);

  // FSM codes
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Captured request
  logic                      action_q;
  logic [REQUESTER_BITS-1:0] req_q;
  logic [SLOT_W-1:0]         slot_q;

  // Result register
  logic                      out_valid_q, out_valid_d;
  logic                      granted_q, granted_d;
  logic [REQUESTER_BITS-1:0] g_req_q, g_req_d;
  logic [SLOT_W-1:0]         g_slot_q, g_slot_d;
  logic [OUTCOME_W-1:0]      outcome_q, outcome_d;
  logic [COUNT_W-1:0]        free_cnt_q, free_cnt_d;
  logic [COUNT_W-1:0]        wait_cnt_q, wait_cnt_d;

  // FIFO side
  fifo_ctrl_t                free_ctrl, wait_ctrl;
  logic [SLOT_W-1:0]         free_head_slot;
  logic [REQUESTER_BITS-1:0] wait_head_req;
  logic [FreeLvlW-1:0]       free_level, free_after;
  logic [WaitLvlW-1:0]       wait_level, wait_after;

  logic accept_in, fire;

  rpwq_free_list #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_free_list (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (free_ctrl),
    .push_slot_i (slot_q),
    .head_slot_o (free_head_slot),
    .level_o     (free_level)
  );

  rpwq_wait_queue #(
    .WAIT_DEPTH     (WAIT_DEPTH),
    .REQUESTER_BITS (REQUESTER_BITS)
  ) u_wait_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (wait_ctrl),
    .push_req_i (req_q),
    .head_req_o (wait_head_req),
    .level_o    (wait_level)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept_in  = in_valid_i && in_ready_o;
  // Decide only when the output register can take the result
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Decision: waiters first, then the pool
  always_comb begin
    free_ctrl = '0;
    wait_ctrl = '0;
    granted_d = 1'b0;
    g_req_d   = '0;
    g_slot_d  = '0;
    outcome_d = OUT_WAIT_FULL;
    if (action_q == ACT_ALLOC) begin
      if (wait_level == '0 && free_level != '0) begin
        free_ctrl.pop = 1'b1;
        granted_d     = 1'b1;
        g_req_d       = req_q;
        g_slot_d      = free_head_slot;
        outcome_d     = OUT_GRANT_NOW;
      end else if (wait_level == WaitFull) begin
        outcome_d = OUT_WAIT_FULL;
      end else begin
        wait_ctrl.push = 1'b1;
        outcome_d      = OUT_QUEUED;
      end
    end else begin
      if (wait_level != '0) begin
        wait_ctrl.pop = 1'b1;
        granted_d     = 1'b1;
        g_req_d       = wait_head_req;
        g_slot_d      = slot_q;
        outcome_d     = OUT_GRANT_NOW;
      end else if (free_level == FreeFull) begin
        outcome_d = OUT_OVERFULL;
      end else begin
        free_ctrl.push = 1'b1;
        outcome_d      = OUT_RETURNED;
      end
    end
    // Gate the strobes to the decide cycle
    free_ctrl.push = free_ctrl.push && fire;
    free_ctrl.pop  = free_ctrl.pop && fire;
    wait_ctrl.push = wait_ctrl.push && fire;
    wait_ctrl.pop  = wait_ctrl.pop && fire;
  end

  // Counts after this request
  always_comb begin
    free_after = free_level;
    wait_after = wait_level;
    if (free_ctrl.push) begin
      free_after = free_level + 1'b1;
    end else if (free_ctrl.pop) begin
      free_after = free_level - 1'b1;
    end
    if (wait_ctrl.push) begin
      wait_after = wait_level + 1'b1;
    end else if (wait_ctrl.pop) begin
      wait_after = wait_level - 1'b1;
    end
    free_cnt_d = COUNT_W'(free_after);
    wait_cnt_d = COUNT_W'(wait_after);
  end

  // Sequencer and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the captured request and the result payload
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      action_q <= action_i;
      req_q    <= requester_id_i;
      slot_q   <= slot_index_i;
    end
    if (fire) begin
      granted_q  <= granted_d;
      g_req_q    <= g_req_d;
      g_slot_q   <= g_slot_d;
      outcome_q  <= outcome_d;
      free_cnt_q <= free_cnt_d;
      wait_cnt_q <= wait_cnt_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign granted_o          = granted_q;
  assign grant_requester_o  = g_req_q;
  assign grant_slot_o       = g_slot_q;
  assign outcome_o          = outcome_q;
  assign free_slots_o       = free_cnt_q;
  assign waiting_requests_o = wait_cnt_q;

endmodule : resource_pool_with_wait_queue

`default_nettype wire

FILE: design/rpwq_free_list.sv
// ----------------------------------------------------------------------------
// rpwq_free_list: FIFO of free slot indices
// Memory-backed FIFO whose reset contents are the slot indices in order;
// a fill count marks which entries have been written since reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwq_free_list #(
  parameter int unsigned POOL_SLOTS = rpwq_pkg::DEF_POOL_SLOTS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire rpwq_pkg::fifo_ctrl_t                  ctrl_i,
  input  wire logic [rpwq_pkg::SLOT_W-1:0]           push_slot_i,
  output logic      [rpwq_pkg::SLOT_W-1:0]           head_slot_o,
  output logic      [$clog2(POOL_SLOTS+1)-1:0]       level_o
);
  import rpwq_pkg::*;

  localparam int unsigned PtrW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned LvlW = $clog2(POOL_SLOTS + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(POOL_SLOTS - 1);
  localparam logic [LvlW-1:0] FullLvl = LvlW'(POOL_SLOTS);

  logic [SLOT_W-1:0] mem_q [POOL_SLOTS];
  logic [SLOT_W-1:0] rd_q;
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [LvlW-1:0]   level_q, level_d;
  logic [LvlW-1:0]   fill_q, fill_d;

  // Memory: write at tail, read the head every cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= push_slot_i;
    end
    rd_q <= mem_q[head_q];
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    level_d = level_q;
    fill_d  = fill_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
      if (fill_q != FullLvl) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      level_d = level_q + 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= FullLvl;
      fill_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
      fill_q  <= fill_d;
    end
  end

  // Entries are written in index order, so the ones below the fill count are
  // live; any other entry still holds its own index.
  assign head_slot_o = (LvlW'(head_q) < fill_q) ? rd_q : SLOT_W'(head_q);
  assign level_o     = level_q;

endmodule : rpwq_free_list

`default_nettype wire

FILE: design/rpwq_wait_queue.sv
// ----------------------------------------------------------------------------
// rpwq_wait_queue: FIFO of waiting requester IDs
// Memory-backed FIFO with a registered read of the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwq_wait_queue #(
  parameter int unsigned WAIT_DEPTH     = rpwq_pkg::DEF_WAIT_DEPTH,
  parameter int unsigned REQUESTER_BITS = rpwq_pkg::DEF_REQUESTER_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rpwq_pkg::fifo_ctrl_t            ctrl_i,
  input  wire logic [REQUESTER_BITS-1:0]       push_req_i,
  output logic      [REQUESTER_BITS-1:0]       head_req_o,
  output logic      [$clog2(WAIT_DEPTH+1)-1:0] level_o
);
  import rpwq_pkg::*;

  localparam int unsigned PtrW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned LvlW = $clog2(WAIT_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(WAIT_DEPTH - 1);

  logic [REQUESTER_BITS-1:0] mem_q [WAIT_DEPTH];
  logic [REQUESTER_BITS-1:0] rd_q;
  logic [PtrW-1:0]           head_q, head_d;
  logic [PtrW-1:0]           tail_q, tail_d;
  logic [LvlW-1:0]           level_q, level_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= push_req_i;
    end
    rd_q <= mem_q[head_q];
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    level_d = level_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      level_d = level_q + 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
    end
  end

  assign head_req_o = rd_q;
  assign level_o    = level_q;

endmodule : rpwq_wait_queue

`default_nettype wire
